>>> hw/rtl/svm_pkg.sv
`default_nettype none

package svm_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int SCALE_W     = 12;
  localparam int PERIOD_W    = 8;
  localparam int VALUE_W     = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 2 * VALUE_W;
  localparam int OUT_TUSER_W = 2;

  localparam logic [VALUE_W-1:0]     VALUE_MAX     = 20'hFFFFF;
  localparam logic [SCALE_W-1:0]     SCALE_RESET   = 12'd1126;
  localparam logic [PERIOD_W-1:0]    PERIOD_RESET  = 8'd100;

  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_SCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_PERIOD    = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/svm_ctrl.sv
`default_nettype none

module svm_ctrl #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output svm_pkg::ctrl_cmd_t  cmd
);
  import svm_pkg::*;

  localparam int NUM_W = SCALE_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] step_cnt_r, step_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt    = S_DIV;
          step_cnt_nxt = CNT_W'(NUM_W - 1);
        end
      end
      S_DIV: begin
        if (step_cnt_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          step_cnt_nxt = step_cnt_r - 1'b1;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_DIV: begin
        cmd.step = 1'b1;
      end
      S_FINISH: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result committed over an untaken result");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DIV))
    else $error("accepted sample did not start the divider");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_cnt_r == '0) |=> (state_r == S_FINISH))
    else $error("divider overran its step count");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

endmodule

`default_nettype wire

>>> hw/rtl/svm_datapath.sv
`default_nettype none

module svm_datapath #(
  parameter int AVERAGE_SHIFT = 4,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire svm_pkg::ctrl_cmd_t                  cmd,
  input  wire logic [svm_pkg::SAMPLE_W-1:0]        sample,
  input  wire logic                                cfg_valid,
  input  wire logic [svm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [svm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [svm_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic [svm_pkg::OUT_TUSER_W-1:0]          out_tuser
);
  import svm_pkg::*;

  localparam int NUM_W = SCALE_W + FRACTION_BITS;
  localparam int QX_W  = (NUM_W > VALUE_W) ? NUM_W : VALUE_W;
  localparam int ACC_W = VALUE_W + AVERAGE_SHIFT + 1;
  localparam logic [VALUE_W-1:0] AVG_RESET = VALUE_W'(9 << (FRACTION_BITS - 1));

  // configuration
  logic [SCALE_W-1:0]  scale_r;
  logic [PERIOD_W-1:0] period_r;

  // divider
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [SAMPLE_W-1:0] div_r, div_nxt;
  logic [SAMPLE_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0]    quot_r, quot_nxt;
  logic                zero_r, zero_nxt;
  logic [SAMPLE_W:0]   rem_sh;
  logic                ge;

  // running state
  logic [VALUE_W-1:0]  avg_r, avg_nxt;
  logic [PERIOD_W-1:0] count_r, count_nxt;
  logic                ind_r, ind_nxt;

  // result register
  logic [VALUE_W-1:0]  supply_out_r;
  logic [VALUE_W-1:0]  avg_out_r;
  logic                ind_out_r;
  logic                zero_out_r;

  logic [QX_W-1:0]     q_ext;
  logic [VALUE_W-1:0]  supply;
  logic [ACC_W-1:0]    acc;
  logic                count_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REFERENCE_SCALE: scale_r  <= cfg_data[SCALE_W-1:0];
        REG_BLINK_PERIOD:    period_r <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // one restoring quotient bit per step
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_comb begin
    num_nxt  = num_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    zero_nxt = zero_r;
    if (cmd.load) begin
      num_nxt  = {scale_r, {FRACTION_BITS{1'b0}}};
      div_nxt  = sample;
      rem_nxt  = '0;
      quot_nxt = '0;
      zero_nxt = (sample == '0);
    end else if (cmd.step) begin
      num_nxt  = {num_r[NUM_W-2:0], 1'b0};
      rem_nxt  = ge ? SAMPLE_W'(rem_sh - {1'b0, div_r}) : rem_sh[SAMPLE_W-1:0];
      quot_nxt = {quot_r[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    zero_r <= zero_nxt;
  end

  assign q_ext = QX_W'(quot_r);

  always_comb begin
    if (zero_r || (q_ext > QX_W'(VALUE_MAX))) begin
      supply = VALUE_MAX;
    end else begin
      supply = q_ext[VALUE_W-1:0];
    end
  end

  // avg * (2^shift - 1) + supply, without a multiplier
  assign acc = ACC_W'({avg_r, {AVERAGE_SHIFT{1'b0}}}) - ACC_W'(avg_r) + ACC_W'(supply);

  assign count_hit = (count_r == period_r);

  always_comb begin
    avg_nxt   = avg_r;
    count_nxt = count_r;
    ind_nxt   = ind_r;
    if (cmd.commit) begin
      avg_nxt   = VALUE_W'(acc >> AVERAGE_SHIFT);
      count_nxt = count_hit ? PERIOD_W'(1) : count_r + 1'b1;
      ind_nxt   = ind_r ^ count_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r   <= AVG_RESET;
      count_r <= '0;
      ind_r   <= 1'b0;
    end else begin
      avg_r   <= avg_nxt;
      count_r <= count_nxt;
      ind_r   <= ind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      supply_out_r <= supply;
      avg_out_r    <= avg_nxt;
      ind_out_r    <= ind_nxt;
      zero_out_r   <= zero_r;
    end
  end

  assign out_tdata = {avg_out_r, supply_out_r};
  assign out_tuser = {zero_out_r, ind_out_r};

endmodule

`default_nettype wire

>>> hw/rtl/supply_voltage_monitor_ema.sv
`default_nettype none

// Supply voltage monitor: each 10-bit converter reading of the bandgap is
// turned into the supply voltage (reference_scale << FRACTION_BITS) / sample,
// truncated and saturated to 20 bits (a zero reading saturates and sets the
// zero_reading flag), and folded into an exponential average with weight
// 1 / 2^AVERAGE_SHIFT that starts at 4.5 V. An indicator bit toggles each
// time the sample count reaches blink_period. One item is processed at a
// time: the sample is taken, the restoring divider yields a quotient of
// 12 + FRACTION_BITS bits, one quotient bit per cycle, and then the
// average is updated and the result register loaded once the output
// register is empty or its result is being taken. The next sample is taken
// while a result waits in the output register. Configuration writes are
// always accepted and should be made only while the block is idle.
module supply_voltage_monitor_ema #(
  parameter int AVERAGE_SHIFT = 4,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [9:0] sample, [15:10] zero
  input  wire logic [svm_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [19:0] supply_q8, [39:20] average_q8
  output logic [svm_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // [0] indicator_on, [1] zero_reading
  output logic [svm_pkg::OUT_TUSER_W-1:0]          out_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [svm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [svm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import svm_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  svm_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  svm_datapath #(
    .AVERAGE_SHIFT (AVERAGE_SHIFT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sample    (in_tdata[SAMPLE_W-1:0]),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import svm_pkg::*;

  localparam int AVG_SHIFT = 4;
  localparam int FRAC_BITS = 8;

  typedef struct packed {
    logic [VALUE_W-1:0] supply;
    logic [VALUE_W-1:0] average;
    logic               indicator;
    logic               zero;
  } supply_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  supply_voltage_monitor_ema #(
    .AVERAGE_SHIFT(AVG_SHIFT),
    .FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the block's registers and running state
  logic [SCALE_W-1:0]  m_scale     = SCALE_RESET;
  logic [PERIOD_W-1:0] m_period    = PERIOD_RESET;
  logic [VALUE_W-1:0]  m_average   = VALUE_W'(9 << (FRAC_BITS - 1));
  logic [7:0]          m_count     = '0;
  logic                m_indicator = 1'b0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  supply_result_t      expected_readings[$];
  int                  mismatches = 0;
  bit                  no_idle    = 1'b0;

  function automatic supply_result_t model_supply_sample(input logic [SAMPLE_W-1:0] s);
    supply_result_t r;
    logic [63:0]    quot;
    logic [63:0]    acc;
    if (s == '0) begin
      r.supply = VALUE_MAX;
      r.zero   = 1'b1;
    end else begin
      quot     = (64'(m_scale) << FRAC_BITS) / 64'(s);
      r.supply = (quot > 64'(VALUE_MAX)) ? VALUE_MAX : quot[VALUE_W-1:0];
      r.zero   = 1'b0;
    end
    acc       = 64'(m_average) * ((64'd1 << AVG_SHIFT) - 64'd1) + 64'(r.supply);
    m_average = VALUE_W'(acc >> AVG_SHIFT);
    if (m_count == m_period) begin
      m_count     = '0;
      m_indicator = ~m_indicator;
    end
    m_count     = m_count + 8'd1;
    r.average   = m_average;
    r.indicator = m_indicator;
    return r;
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_REFERENCE_SCALE: m_scale = data[SCALE_W-1:0];
      REG_BLINK_PERIOD:    m_period = data[PERIOD_W-1:0];
      default: ;
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 30);
    return $urandom_range(31, 120);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return SAMPLE_W'($urandom_range(1, 8));
    if (r < 25) return SAMPLE_W'($urandom_range(1000, 1023));
    return SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  // sample driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_readings.push_back(model_supply_sample(in_tdata[SAMPLE_W-1:0]));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_tdata  <= IN_TDATA_W'(pending_samples.pop_front());
          in_tvalid <= 1'b1;
          send_gap  = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure and an occasional long hold-off
  int stall_left   = 0;
  int hold_left    = 0;
  int results_seen = 0;
  always @(posedge clk) begin
    supply_result_t got;
    supply_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.supply    = out_tdata[VALUE_W-1:0];
        got.average   = out_tdata[2*VALUE_W-1:VALUE_W];
        got.indicator = out_tuser[0];
        got.zero      = out_tuser[1];
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: supply=%h average=%h indicator=%b zero=%b",
                     got.supply, got.average, got.indicator, got.zero);
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected supply=%h average=%h indicator=%b zero=%b,",
                        " got supply=%h average=%h indicator=%b zero=%b"},
                       results_seen, want.supply, want.average, want.indicator, want.zero,
                       got.supply, got.average, got.indicator, got.zero);
          end
        end
        results_seen++;
        if (results_seen % 300 == 120)
          hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0)
          stall_left = pick_gap();
      end
    end
  end

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // all samples transferred and every result back, then leave the block idle before the next settings
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_tvalid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int n;
    int len;
    logic [PERIOD_W-1:0] period;
    logic [SCALE_W-1:0]  scale;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero reading, extremes, alternating bits
    pending_samples = '{10'd0, 10'd1, 10'd2, 10'd1023, 10'h155, 10'h2AA, 10'd512, 10'd3};
    wait_idle();

    // largest scale, shortest period, writes to unused indexes
    write_cfg(REG_REFERENCE_SCALE, 12'd4095);
    write_cfg(REG_BLINK_PERIOD, 12'h301);
    write_cfg(2'd2, 12'hFFF);
    write_cfg(2'd3, 12'hA5A);
    pending_samples = '{10'd1, 10'd0, 10'd1023, 10'd7};
    wait_idle();

    // scale of zero gives zero supply but for a zero reading, period of zero toggles on wrap
    write_cfg(REG_REFERENCE_SCALE, 12'd0);
    write_cfg(REG_BLINK_PERIOD, 12'hF00);
    pending_samples = '{10'd5, 10'd0, 10'd1023, 10'd1};
    wait_idle();

    write_cfg(REG_REFERENCE_SCALE, 12'd1);
    write_cfg(REG_BLINK_PERIOD, 12'hAFF);
    pending_samples = '{10'd1, 10'd1023, 10'd0};
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 5))
        0:       scale = '0;
        1:       scale = 12'd1;
        2:       scale = 12'd4095;
        default: scale = SCALE_W'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 5))
        0:       period = '0;
        1:       period = 8'd1;
        2:       period = 8'd255;
        3:       period = 8'd2;
        default: period = PERIOD_W'($urandom_range(0, 255));
      endcase
      len = $urandom_range(60, 140);
      // a long period lets the count climb, then a short one sits below it
      if (p == 4) period = 8'd255;
      if (p == 5) begin
        period = PERIOD_W'($urandom_range(1, 10));
        len    = 200;
      end
      write_cfg(REG_REFERENCE_SCALE, {$urandom_range(0, 1) ? 12'hFFF : 12'h000} & scale);
      write_cfg(REG_BLINK_PERIOD, {4'($urandom), period});
      if ($urandom_range(0, 2) == 0)
        write_cfg(CFG_INDEX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      for (n = 0; n < len; n++)
        pending_samples.push_back(random_sample());
      wait_idle();
    end

    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
